// ===== sv/tddd_pkg.sv =====
package tddd_pkg;

    // Default configuration
    localparam int MAX_ELEMENTS_DEF = 65535;
    localparam int PAIR_DEPTH_DEF   = 4;
    localparam int OUT_DEPTH_DEF    = 4;

    // Largest byte count one value may use
    localparam logic [3:0] MAX_BYTES = 4'd8;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_FLAG = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic        block_start;
        logic [15:0] element_count;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] timestamp;
        logic               last;
        logic               length_error;
    } t_out_item;

    // One or two decoded deltas-of-delta produced by a single input item
    typedef struct packed {
        logic        two;
        logic        first;
        logic        last0;
        logic        err0;
        logic        last1;
        logic        err1;
        logic [63:0] dod0;
        logic [63:0] dod1;
    } t_pair;

    // Undo the zigzag mapping
    function automatic logic [63:0] zigzag_dec(input logic [63:0] zz);
        zigzag_dec = {1'b0, zz[63:1]} ^ {64{zz[0]}};
    endfunction

    // Cap a byte count nibble at the largest legal count
    function automatic logic [3:0] len_clamp(input logic [3:0] nib);
        len_clamp = (nib > MAX_BYTES) ? MAX_BYTES : nib;
    endfunction

endpackage

// ===== sv/timestamp_delta_of_delta_decoder_unit.sv =====
// Delta-of-delta timestamp block decoder.
// Input queue side: drive i_item and raise push; the byte is taken at a
// clock edge where push is high and full is low. A byte with block_start
// set is the header of a new block and carries its element count.
// Result queue side: while empty is low the oldest timestamp is on o_item;
// it is taken at an edge where pop is high. last marks the final
// timestamp of a block, length_error a value whose byte count was capped.
// Throughput: one byte per cycle while full is low; results leave at up to one per cycle.
// A flag byte that completes two values yields two results, which drain
// one after the other through the back end's accumulators.
// After the byte that completes it is accepted, a result passes through
// the decode queue, the delta adder stage and the result queue to o_item;
// a second result of the same byte follows it.
// Reset: synchronous, active low; both queues empty, decoder idle until a
// header byte arrives. When pop stays low the result queue fills, the back
// end stops, the decode queue fills and full is raised.
module timestamp_delta_of_delta_decoder_unit
    import tddd_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int PAIR_DEPTH   = PAIR_DEPTH_DEF,
    parameter int OUT_DEPTH    = OUT_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_item
);

    localparam int PairCntW = $clog2(PAIR_DEPTH + 1);
    localparam int OutCntW  = $clog2(OUT_DEPTH + 1);

    logic                accept;
    logic                pair_push;
    t_pair               pair_in;
    logic                pair_full;
    logic                pair_empty;
    logic                pair_pop;
    t_pair               pair_head;
    logic [PairCntW-1:0] pair_count;
    logic                out_push;
    t_out_item           out_in;
    logic                out_full;
    logic [OutCntW-1:0]  out_count;

    assign full   = pair_full;
    assign accept = push && !pair_full;

    tddd_front #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .o_pair_push(pair_push),
        .o_pair     (pair_in)
    );

    tddd_fifo #(
        .WIDTH($bits(t_pair)),
        .DEPTH(PAIR_DEPTH)
    ) u_pair_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (pair_push),
        .i_data (pair_in),
        .o_full (pair_full),
        .i_pop  (pair_pop),
        .o_empty(pair_empty),
        .o_data (pair_head),
        .o_count(pair_count)
    );

    tddd_back #(
        .OUT_DEPTH(OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pair_valid(!pair_empty),
        .i_pair      (pair_head),
        .o_pair_pop  (pair_pop),
        .i_out_count (out_count),
        .o_out_push  (out_push),
        .o_out_item  (out_in)
    );

    tddd_fifo #(
        .WIDTH($bits(t_out_item)),
        .DEPTH(OUT_DEPTH)
    ) u_out_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (out_push),
        .i_data (out_in),
        .o_full (out_full),
        .i_pop  (pop),
        .o_empty(empty),
        .o_data (o_item),
        .o_count(out_count)
    );

`ifndef SYNTH
    // The back end never hands a result to a full result queue
    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_push |-> !out_full)
        else $error("result written into full result queue");

    // The front end only emits values for accepted bytes
    a_pair_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pair_push |-> (accept && pair_count != PairCntW'(PAIR_DEPTH)))
        else $error("decode queue written without an accepted byte");

    // A header byte never yields a value
    a_header_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.block_start) |-> !pair_push)
        else $error("header byte produced a value");
`endif

endmodule

// ===== sv/tddd_fifo.sv =====
module tddd_fifo
    import tddd_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic [WIDTH-1:0]           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr, n_wr;
    logic [PtrW-1:0]  r_rd, n_rd;
    logic [CntW-1:0]  r_count, n_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    // Advance pointers and occupancy
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (wr_en) begin
            n_wr = (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (rd_en) begin
            n_rd = (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Store the incoming item
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== sv/tddd_front.sv =====
module tddd_front
    import tddd_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_pair_push,
    output t_pair    o_pair
);

    localparam int CntBits = $clog2(MAX_ELEMENTS + 1);
    localparam int ElemW   = (CntBits < 16) ? CntBits : 16;

    t_phase           r_phase, n_phase;
    logic [ElemW-1:0] r_elem, n_elem;
    logic [3:0]       r_bytes, n_bytes;
    logic [3:0]       r_second, n_second;
    logic             r_lane, n_lane;
    logic [2:0]       r_pos, n_pos;
    logic [63:0]      r_asm, n_asm;
    logic             r_err, n_err;
    logic             r_first, n_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_elem   <= '0;
            r_bytes  <= '0;
            r_second <= '0;
            r_lane   <= 1'b0;
            r_pos    <= '0;
            r_asm    <= '0;
            r_err    <= 1'b0;
            r_first  <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_elem   <= n_elem;
            r_bytes  <= n_bytes;
            r_second <= n_second;
            r_lane   <= n_lane;
            r_pos    <= n_pos;
            r_asm    <= n_asm;
            r_err    <= n_err;
            r_first  <= n_first;
        end
    end

    // Parse header, flag and value bytes; emit finished values
    always_comb begin
        logic [ElemW-1:0] cnt_cl;
        logic [ElemW-1:0] el1;
        logic [3:0]       nib1;
        logic [3:0]       nib2;
        logic [3:0]       sec_len;
        logic [3:0]       bytes_dec;
        logic [63:0]      val;
        logic             fin;
        logic [63:0]      fin_zz;
        logic             fin_err;
        logic             fin_lane;

        n_phase     = r_phase;
        n_elem      = r_elem;
        n_bytes     = r_bytes;
        n_second    = r_second;
        n_lane      = r_lane;
        n_pos       = r_pos;
        n_asm       = r_asm;
        n_err       = r_err;
        n_first     = r_first;
        o_pair_push = 1'b0;
        o_pair      = '0;

        cnt_cl    = (32'(i_item.element_count) > MAX_ELEMENTS) ?
                    ElemW'(MAX_ELEMENTS) : ElemW'(i_item.element_count);
        el1       = r_elem - 1'b1;
        nib1      = i_item.byte_value[3:0];
        nib2      = i_item.byte_value[7:4];
        sec_len   = r_second;
        bytes_dec = (r_bytes != '0) ? r_bytes - 1'b1 : r_bytes;
        val       = r_asm | (64'(i_item.byte_value) << {r_pos, 3'b000});
        fin       = 1'b0;
        fin_zz    = '0;
        fin_err   = 1'b0;
        fin_lane  = 1'b0;

        if (i_accept) begin
            if (i_item.block_start) begin
                // Restart the block
                n_phase  = (cnt_cl == '0) ? PH_IDLE : PH_FLAG;
                n_elem   = cnt_cl;
                n_bytes  = '0;
                n_second = '0;
                n_lane   = 1'b0;
                n_pos    = '0;
                n_asm    = '0;
                n_err    = 1'b0;
                n_first  = 1'b1;
            end else begin
                case (r_phase)
                    PH_FLAG: begin
                        sec_len  = (r_elem > ElemW'(1)) ? nib2 : 4'd0;
                        n_second = sec_len;
                        if (nib1 == 4'd0) begin
                            fin      = 1'b1;
                            fin_lane = 1'b0;
                        end else begin
                            n_phase = PH_DATA;
                            n_bytes = len_clamp(nib1);
                            n_err   = (nib1 > MAX_BYTES);
                            n_lane  = 1'b0;
                            n_pos   = '0;
                            n_asm   = '0;
                        end
                    end
                    PH_DATA: begin
                        n_pos   = r_pos + 1'b1;
                        n_bytes = bytes_dec;
                        if (bytes_dec == '0) begin
                            fin      = 1'b1;
                            fin_zz   = val;
                            fin_err  = r_err;
                            fin_lane = r_lane;
                        end else begin
                            n_asm = val;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase

                // Finish the current value and open the next one
                if (fin) begin
                    o_pair_push  = 1'b1;
                    o_pair.first = r_first;
                    o_pair.dod0  = zigzag_dec(fin_zz);
                    o_pair.last0 = (r_elem == ElemW'(1));
                    o_pair.err0  = fin_err;
                    n_first      = 1'b0;
                    n_elem       = el1;
                    n_asm        = '0;
                    n_pos        = '0;
                    n_err        = 1'b0;
                    if (el1 == '0) begin
                        n_phase = PH_IDLE;
                    end else if (!fin_lane) begin
                        n_lane = 1'b1;
                        if (sec_len == 4'd0) begin
                            o_pair.two   = 1'b1;
                            o_pair.dod1  = '0;
                            o_pair.last1 = (el1 == ElemW'(1));
                            o_pair.err1  = 1'b0;
                            n_elem       = el1 - 1'b1;
                            n_bytes      = '0;
                            n_phase      = (el1 == ElemW'(1)) ? PH_IDLE : PH_FLAG;
                        end else begin
                            n_phase = PH_DATA;
                            n_bytes = len_clamp(sec_len);
                            n_err   = (sec_len > MAX_BYTES);
                        end
                    end else begin
                        n_phase = PH_FLAG;
                    end
                end
            end
        end
    end

endmodule

// ===== sv/tddd_back.sv =====
module tddd_back
    import tddd_pkg::*;
#(
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_pair_valid,
    input  t_pair                          i_pair,
    output logic                           o_pair_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] i_out_count,
    output logic                           o_out_push,
    output t_out_item                      o_out_item
);

    logic        r_sel;
    logic        r_a_valid;
    logic        r_a_first;
    logic        r_a_last;
    logic        r_a_err;
    logic [63:0] r_delta;
    logic [63:0] r_ts;
    logic        issue;
    logic        first;
    logic [63:0] dod;
    logic [63:0] ts_next;

    // Issue only when the result queue has room for everything in flight
    assign issue      = i_pair_valid &&
                        ((32'(i_out_count) + 32'(r_a_valid)) < OUT_DEPTH);
    assign o_pair_pop = issue && (r_sel || !i_pair.two);
    assign first      = i_pair.first && !r_sel;
    assign dod        = r_sel ? i_pair.dod1 : i_pair.dod0;

    // Stage A: accumulate the delta
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel     <= 1'b0;
            r_a_valid <= 1'b0;
            r_delta   <= '0;
        end else begin
            r_a_valid <= issue;
            if (issue) begin
                r_sel   <= !o_pair_pop;
                r_delta <= (first ? 64'd0 : r_delta) + dod;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_a_first <= first;
            r_a_last  <= r_sel ? i_pair.last1 : i_pair.last0;
            r_a_err   <= r_sel ? i_pair.err1 : i_pair.err0;
        end
    end

    // Stage B: accumulate the timestamp and hand it to the result queue
    assign ts_next = (r_a_first ? 64'd0 : r_ts) + r_delta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts <= '0;
        end else if (r_a_valid) begin
            r_ts <= ts_next;
        end
    end

    assign o_out_push              = r_a_valid;
    assign o_out_item.timestamp    = $signed(ts_next);
    assign o_out_item.last         = r_a_last;
    assign o_out_item.length_error = r_a_err;

endmodule
